// ===== sv/rfr_pkg.sv =====
`timescale 1ns / 1ps

package rfr_pkg;

    // Built frame size limits and the width of the size registers
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int SIZE_W     = 9;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = 1 + ROW_W + COL_W;
    localparam int MEM_DEPTH  = 2 ** ADDR_W;
    localparam int PIXEL_W    = 24;

    localparam logic [SIZE_W-1:0] MAX_W_SZ   = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] MAX_H_SZ   = SIZE_W'(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] RESET_SIZE = SIZE_W'(256);

    // Output queue, depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // Per-transaction command from the address generator to the back end
    typedef struct packed {
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              valid;
        logic              last;
    } front_cmd_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               valid;
        logic               last;
    } result_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max_v);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > max_v)
            r = max_v;
        return r;
    endfunction

endpackage

// ===== sv/rfr_front.sv =====
`timescale 1ns / 1ps

module rfr_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfr_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                             accept,
    output rfr_pkg::front_cmd_t              cmd
);

    logic [rfr_pkg::SIZE_W-1:0] width_reg,  width_next;
    logic [rfr_pkg::SIZE_W-1:0] height_reg, height_next;
    logic [rfr_pkg::COL_W-1:0]  wc_reg,     wc_next;
    logic [rfr_pkg::ROW_W-1:0]  wr_reg,     wr_next;
    logic [rfr_pkg::COL_W-1:0]  ror_reg,    ror_next;
    logic [rfr_pkg::ROW_W-1:0]  roc_reg,    roc_next;
    logic                       bank_reg,   bank_next;
    logic                       active_reg, active_next;
    logic [rfr_pkg::SIZE_W-1:0] rd_w_reg,   rd_w_next;
    logic [rfr_pkg::SIZE_W-1:0] rd_h_reg,   rd_h_next;

    logic [rfr_pkg::SIZE_W-1:0] w, h;
    logic [rfr_pkg::COL_W-1:0]  wc_eff;
    logic [rfr_pkg::ROW_W-1:0]  wr_eff;
    logic [rfr_pkg::SIZE_W-1:0] wc_inc, wr_inc, ror_inc, roc_inc, src_row;
    logic                       col_wrap, row_wrap, ror_wrap, roc_wrap;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                rfr_pkg::REG_FRAME_WIDTH:  width_next  = cfg_data;
                rfr_pkg::REG_FRAME_HEIGHT: height_next = cfg_data;
            endcase
        end
    end

    assign w = rfr_pkg::clamp_size(width_reg,  rfr_pkg::MAX_W_SZ);
    assign h = rfr_pkg::clamp_size(height_reg, rfr_pkg::MAX_H_SZ);

    // A size shrunk mid-frame leaves a counter beyond the limit: restart it at zero
    assign wc_eff = (rfr_pkg::SIZE_W'(wc_reg) >= w) ? '0 : wc_reg;
    assign wr_eff = (rfr_pkg::SIZE_W'(wr_reg) >= h) ? '0 : wr_reg;
    assign wc_inc = rfr_pkg::SIZE_W'(wc_eff) + rfr_pkg::SIZE_W'(1);
    assign wr_inc = rfr_pkg::SIZE_W'(wr_eff) + rfr_pkg::SIZE_W'(1);
    assign col_wrap = wc_inc >= w;
    assign row_wrap = wr_inc >= h;

    // Rotated readout: output row = source column, output column counts source rows upward
    assign src_row  = rd_h_reg - rfr_pkg::SIZE_W'(1) - rfr_pkg::SIZE_W'(roc_reg);
    assign roc_inc  = rfr_pkg::SIZE_W'(roc_reg) + rfr_pkg::SIZE_W'(1);
    assign ror_inc  = rfr_pkg::SIZE_W'(ror_reg) + rfr_pkg::SIZE_W'(1);
    assign roc_wrap = roc_inc >= rd_h_reg;
    assign ror_wrap = ror_inc >= rd_w_reg;

    always_comb
    begin
        cmd.wr_addr = {bank_reg, wr_eff, wc_eff};
        cmd.rd_addr = {~bank_reg, src_row[rfr_pkg::ROW_W-1:0], ror_reg};
        cmd.valid   = active_reg;
        cmd.last    = active_reg & roc_wrap & ror_wrap;
    end

    always_comb
    begin
        wc_next     = wc_reg;
        wr_next     = wr_reg;
        ror_next    = ror_reg;
        roc_next    = roc_reg;
        bank_next   = bank_reg;
        active_next = active_reg;
        rd_w_next   = rd_w_reg;
        rd_h_next   = rd_h_reg;
        if (accept)
        begin
            if (active_reg)
            begin
                if (roc_wrap)
                begin
                    roc_next = '0;
                    if (ror_wrap)
                    begin
                        ror_next    = '0;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        ror_next = ror_inc[rfr_pkg::COL_W-1:0];
                    end
                end
                else
                begin
                    roc_next = roc_inc[rfr_pkg::ROW_W-1:0];
                end
            end
            if (col_wrap)
            begin
                wc_next = '0;
                if (row_wrap)
                begin
                    // frame complete: swap banks, restart readout with this geometry
                    wr_next     = '0;
                    bank_next   = ~bank_reg;
                    rd_w_next   = w;
                    rd_h_next   = h;
                    ror_next    = '0;
                    roc_next    = '0;
                    active_next = 1'b1;
                end
                else
                begin
                    wr_next = wr_inc[rfr_pkg::ROW_W-1:0];
                end
            end
            else
            begin
                wc_next = wc_inc[rfr_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rfr_pkg::RESET_SIZE;
            height_reg <= rfr_pkg::RESET_SIZE;
            wc_reg     <= '0;
            wr_reg     <= '0;
            ror_reg    <= '0;
            roc_reg    <= '0;
            bank_reg   <= 1'b0;
            active_reg <= 1'b0;
            rd_w_reg   <= '0;
            rd_h_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            wc_reg     <= wc_next;
            wr_reg     <= wr_next;
            ror_reg    <= ror_next;
            roc_reg    <= roc_next;
            bank_reg   <= bank_next;
            active_reg <= active_next;
            rd_w_reg   <= rd_w_next;
            rd_h_reg   <= rd_h_next;
        end
    end

endmodule

// ===== sv/rfr_frame_ram.sv =====
`timescale 1ns / 1ps

module rfr_frame_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [rfr_pkg::ADDR_W-1:0]   waddr,
    input  logic [rfr_pkg::PIXEL_W-1:0]  wdata,
    input  logic                         re,
    input  logic [rfr_pkg::ADDR_W-1:0]   raddr,
    output logic [rfr_pkg::PIXEL_W-1:0]  rdata
);

    logic [rfr_pkg::PIXEL_W-1:0] mem [rfr_pkg::MEM_DEPTH];
    logic [rfr_pkg::PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/rfr_outq.sv =====
`timescale 1ns / 1ps

module rfr_outq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         issue,
    input  logic                         issue_valid,
    input  logic                         issue_last,
    input  logic [rfr_pkg::PIXEL_W-1:0]  rd_data,
    output logic                         space,
    output logic                         result_valid,
    input  logic                         result_stall,
    output rfr_pkg::result_t             head
);

    logic                          pend_reg,  pend_next;
    logic                          mvalid_reg, mlast_reg;
    rfr_pkg::result_t              fifo_reg [rfr_pkg::QUEUE_DEPTH];
    logic [rfr_pkg::QPTR_W-1:0]    wptr_reg,  wptr_next;
    logic [rfr_pkg::QPTR_W-1:0]    rptr_reg,  rptr_next;
    logic [rfr_pkg::QCNT_W-1:0]    count_reg, count_next;
    rfr_pkg::result_t              entry;
    logic                          push, pop;

    // RAM data lands in the cycle after issue; a slot is reserved for it at issue time
    assign push = pend_reg;
    assign pop  = result_valid & ~result_stall;
    assign result_valid = count_reg != '0;
    assign space = (count_reg + rfr_pkg::QCNT_W'(pend_reg)) < rfr_pkg::QCNT_W'(rfr_pkg::QUEUE_DEPTH);
    assign head  = fifo_reg[rptr_reg];

    always_comb
    begin
        entry.pixel = mvalid_reg ? rd_data : '0;
        entry.valid = mvalid_reg;
        entry.last  = mlast_reg;
        pend_next   = issue;
        wptr_next   = push ? wptr_reg + rfr_pkg::QPTR_W'(1) : wptr_reg;
        rptr_next   = pop  ? rptr_reg + rfr_pkg::QPTR_W'(1) : rptr_reg;
        count_next  = count_reg + rfr_pkg::QCNT_W'(push) - rfr_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            pend_reg  <= pend_next;
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            mvalid_reg <= issue_valid;
            mlast_reg  <= issue_last;
        end
        if (push)
            fifo_reg[wptr_reg] <= entry;
    end

endmodule

// ===== sv/rgb_frame_rotate_cw90.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// config    cfg_we                      cfg_index, cfg_data
// input     in_valid / in_stall         pixel_in
// result    result_valid / result_stall pixel_out, out_valid, frame_last
//
// One pixel per clock sustained while in_stall is low; each input transaction yields
// one result transaction. A result becomes visible after the registered RAM read and
// then the output queue. Rate is set by the single write + single read port RAM.
// No clearing pass after reset; the first frame returns out_valid = 0.
// in_stall rises only when the 4-entry output queue plus the in-flight read is full.

module rgb_frame_rotate_cw90 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rfr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfr_pkg::SIZE_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rfr_pkg::PIXEL_W-1:0]      pixel_in,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [rfr_pkg::PIXEL_W-1:0]      pixel_out,
    output logic                             out_valid,
    output logic                             frame_last
);

    rfr_pkg::front_cmd_t         cmd;
    rfr_pkg::result_t            head;
    logic                        accept;
    logic                        space;
    logic [rfr_pkg::PIXEL_W-1:0] rd_data;

    assign in_stall = ~space;
    assign accept   = in_valid & space;

    rfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .cmd       (cmd)
    );

    rfr_frame_ram u_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (cmd.wr_addr),
        .wdata (pixel_in),
        .re    (accept),
        .raddr (cmd.rd_addr),
        .rdata (rd_data)
    );

    rfr_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .issue        (accept),
        .issue_valid  (cmd.valid),
        .issue_last   (cmd.last),
        .rd_data      (rd_data),
        .space        (space),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .head         (head)
    );

    assign pixel_out  = head.pixel;
    assign out_valid  = head.valid;
    assign frame_last = head.last;

endmodule

// ===== sv/rfr_checker.sv =====
`timescale 1ns / 1ps

module rfr_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  logic [rfr_pkg::PIXEL_W-1:0]  pixel_out,
    input  logic                         out_valid,
    input  logic                         frame_last
);

    // frame end marker only on a real pixel
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && frame_last |-> out_valid)
        else $error("frame_last without out_valid");

    // filler results carry a zero pixel
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_valid |-> pixel_out == '0)
        else $error("nonzero pixel on filler result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(pixel_out)
            && $stable(out_valid) && $stable(frame_last))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

endmodule

bind rgb_frame_rotate_cw90 rfr_checker u_rfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_out    (pixel_out),
    .out_valid    (out_valid),
    .frame_last   (frame_last)
);

// ===== bench/rotate_checker.sv =====
`timescale 1ns / 1ps

module rotate_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rfr_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [rfr_pkg::PIXEL_W-1:0]   pixel_in,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  logic [rfr_pkg::PIXEL_W-1:0]   pixel_out,
    input  logic                          out_valid,
    input  logic                          frame_last,
    output int                            pending,
    output int                            errors
);

    // Predicts the rotated stream at each input transaction and compares
    // every result transaction against the oldest prediction.

    // Two banks of MAX_HEIGHT x MAX_WIDTH, addressed {bank, row, col}
    logic [rfr_pkg::PIXEL_W-1:0] bank_pix [0:2*rfr_pkg::MAX_WIDTH*rfr_pkg::MAX_HEIGHT-1];

    logic [rfr_pkg::SIZE_W-1:0] size_w;
    logic [rfr_pkg::SIZE_W-1:0] size_h;
    int                         wr_col;
    int                         wr_row;
    int                         rd_row;
    int                         rd_col;
    int                         rd_w;
    int                         rd_h;
    logic                       wr_bank;
    logic                       prev_ready;
    logic                       rd_busy;

    rfr_pkg::result_t rotated_expect_q [$];
    rfr_pkg::result_t want;
    rfr_pkg::result_t next_exp;
    int               fail_cnt = 0;

    function automatic rfr_pkg::result_t predict_rotated_pixel(
        input logic [rfr_pkg::PIXEL_W-1:0] pix);
        rfr_pkg::result_t r;
        int               w;
        int               h;
        int               src_row;
        r = '0;
        w = (size_w == '0) ? 1 :
            ((size_w > rfr_pkg::MAX_WIDTH) ? rfr_pkg::MAX_WIDTH : int'(size_w));
        h = (size_h == '0) ? 1 :
            ((size_h > rfr_pkg::MAX_HEIGHT) ? rfr_pkg::MAX_HEIGHT : int'(size_h));

        // readout of the finished frame, rotated raster order
        if (prev_ready && rd_busy)
        begin
            src_row = rd_h - 1 - rd_col;
            r.pixel = bank_pix[{~wr_bank, src_row[7:0], rd_row[7:0]}];
            r.valid = 1'b1;
            if (rd_col + 1 >= rd_h)
            begin
                rd_col = 0;
                if (rd_row + 1 >= rd_w)
                begin
                    rd_row  = 0;
                    r.last  = 1'b1;
                    rd_busy = 1'b0;
                end
                else
                begin
                    rd_row++;
                end
            end
            else
            begin
                rd_col++;
            end
        end

        // counters left beyond a shrunk size wrap before the write
        if (wr_col >= w)
            wr_col = 0;
        if (wr_row >= h)
            wr_row = 0;
        bank_pix[{wr_bank, wr_row[7:0], wr_col[7:0]}] = pix;
        if (wr_col + 1 >= w)
        begin
            wr_col = 0;
            if (wr_row + 1 >= h)
            begin
                wr_row     = 0;
                wr_bank    = ~wr_bank;
                prev_ready = 1'b1;
                rd_w       = w;
                rd_h       = h;
                rd_row     = 0;
                rd_col     = 0;
                rd_busy    = 1'b1;
            end
            else
            begin
                wr_row++;
            end
        end
        else
        begin
            wr_col++;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_w     = rfr_pkg::RESET_SIZE;
            size_h     = rfr_pkg::RESET_SIZE;
            wr_col     = 0;
            wr_row     = 0;
            rd_row     = 0;
            rd_col     = 0;
            rd_w       = 0;
            rd_h       = 0;
            wr_bank    = 1'b0;
            prev_ready = 1'b0;
            rd_busy    = 1'b0;
            rotated_expect_q.delete();
            pending <= 0;
            errors  <= fail_cnt;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == rfr_pkg::REG_FRAME_WIDTH)
                    size_w = cfg_data;
                else if (cfg_index == rfr_pkg::REG_FRAME_HEIGHT)
                    size_h = cfg_data;
            end

            if (in_valid && !in_stall)
            begin
                next_exp = predict_rotated_pixel(pixel_in);
                rotated_expect_q = {rotated_expect_q, next_exp};
            end

            if (result_valid && !result_stall)
            begin
                if (rotated_expect_q.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("%0t: unexpected result: pixel %h valid %b last %b",
                                 $realtime, pixel_out, out_valid, frame_last);
                    fail_cnt++;
                end
                else
                begin
                    want = rotated_expect_q.pop_front();
                    if (pixel_out !== want.pixel || out_valid !== want.valid ||
                        frame_last !== want.last)
                    begin
                        if (fail_cnt < 10)
                            $display({"%0t: mismatch: expected pixel %h valid %b last %b,",
                                      " got pixel %h valid %b last %b"},
                                     $realtime, want.pixel, want.valid, want.last,
                                     pixel_out, out_valid, frame_last);
                        fail_cnt++;
                    end
                end
            end

            pending <= rotated_expect_q.size();
            errors  <= fail_cnt;
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [rfr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rfr_pkg::SIZE_W-1:0]    cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [rfr_pkg::PIXEL_W-1:0]   pixel_in;
    logic                          result_valid;
    logic                          result_stall;
    logic [rfr_pkg::PIXEL_W-1:0]   pixel_out;
    logic                          out_valid;
    logic                          frame_last;
    int                            pending;
    int                            errors;

    // effective (saturated) frame size currently programmed
    int cur_w = rfr_pkg::MAX_WIDTH;
    int cur_h = rfr_pkg::MAX_HEIGHT;
    int items_sent = 0;
    int cycle_cnt = 0;
    bit idle_on = 1'b1;
    int hold_left = 0;
    int stall_pick;

    rgb_frame_rotate_cw90 i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_out    (pixel_out),
        .out_valid    (out_valid),
        .frame_last   (frame_last)
    );

    rotate_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_in     (pixel_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pixel_out    (pixel_out),
        .out_valid    (out_valid),
        .frame_last   (frame_last),
        .pending      (pending),
        .errors       (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure: short bursts mostly, an occasional long stall
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (!idle_on)
            result_stall <= 1'b0;
        else if (result_stall)
        begin
            result_stall <= 1'b0;
            hold_left <= $urandom_range(0, 12);
        end
        else
        begin
            stall_pick = $urandom_range(0, 99);
            result_stall <= 1'b1;
            hold_left <= (stall_pick < 90) ? $urandom_range(0, 2) : $urandom_range(10, 60);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(input logic [rfr_pkg::PIXEL_W-1:0] pix);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(rfr_pkg::PIXEL_W'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // let the read pipeline and output queue settle
        repeat (4) @(posedge clk);
    endtask

    task automatic set_size(input logic [rfr_pkg::SIZE_W-1:0] wv,
                            input logic [rfr_pkg::SIZE_W-1:0] hv);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= rfr_pkg::REG_FRAME_WIDTH;
        cfg_data  <= wv;
        @(posedge clk);
        cfg_index <= rfr_pkg::REG_FRAME_HEIGHT;
        cfg_data  <= hv;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_w = (wv == '0) ? 1 :
                ((wv > rfr_pkg::MAX_WIDTH) ? rfr_pkg::MAX_WIDTH : int'(wv));
        cur_h = (hv == '0) ? 1 :
                ((hv > rfr_pkg::MAX_HEIGHT) ? rfr_pkg::MAX_HEIGHT : int'(hv));
    endtask

    // Shrink the size part way through a frame, then finish that frame.
    // Only shrinking keeps every entry of the next readout written.
    task automatic resize_mid_frame(input int done, input int nw, input int nh);
        int col;
        int row;
        int rest;
        col = done % cur_w;
        row = done / cur_w;
        send_random(done);
        set_size(rfr_pkg::SIZE_W'(nw), rfr_pkg::SIZE_W'(nh));
        if (col >= cur_w)
            col = 0;
        if (row >= cur_h)
            row = 0;
        rest = (cur_h - 1 - row) * cur_w + (cur_w - col);
        send_random(rest);
    endtask

    initial
    begin
        int                         start;
        int                         pick;
        logic [rfr_pkg::SIZE_W-1:0] wv;
        logic [rfr_pkg::SIZE_W-1:0] hv;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= rfr_pkg::REG_FRAME_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        pixel_in  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first frame has nothing to read out, second shows it rotated
        set_size(9'd2, 9'd2);
        send_pixel(24'h000000); send_pixel(24'hFFFFFF);
        send_pixel(24'h000001); send_pixel(24'h800000);
        send_pixel(24'h0000FF); send_pixel(24'h00FF00);
        send_pixel(24'hFF0000); send_pixel(24'h5AA5C3);

        // zero size acts as one
        set_size(9'd0, 9'd0);
        send_random(2);
        // larger frame after a 1x1 one: readout runs dry
        set_size(9'd3, 9'd2);
        send_random(6);
        // smaller frame: readout of the 3x2 frame is cut off
        set_size(9'd1, 9'd2);
        send_random(2);
        set_size(9'd3, 9'd3);
        resize_mid_frame(4, 2, 2);
        set_size(9'd2, 9'd2);
        send_random(4);

        // widest and tallest frames, sizes above the limit saturate
        set_size(9'd300, 9'd1);
        send_random(cur_w * cur_h);
        set_size(9'd1, 9'd511);
        send_random(cur_w * cur_h);

        start = items_sent;
        while (items_sent - start < 100)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick = int'($urandom_range(0, 99));
            if (pick < 80)
            begin
                wv = rfr_pkg::SIZE_W'($urandom_range(1, 8));
                hv = rfr_pkg::SIZE_W'($urandom_range(1, 8));
            end
            else if (pick < 88)
            begin
                wv = rfr_pkg::SIZE_W'($urandom_range(9, 40));
                hv = rfr_pkg::SIZE_W'($urandom_range(1, 3));
            end
            else if (pick < 95)
            begin
                wv = rfr_pkg::SIZE_W'($urandom_range(1, 3));
                hv = rfr_pkg::SIZE_W'($urandom_range(9, 40));
            end
            else
            begin
                wv = $urandom_range(0, 1) ? 9'd0 : rfr_pkg::SIZE_W'($urandom_range(1, 4));
                hv = (wv != '0) ? 9'd0 : rfr_pkg::SIZE_W'($urandom_range(1, 4));
            end
            set_size(wv, hv);
            send_random(cur_w * cur_h * int'($urandom_range(1, 3)));
            if (cur_w * cur_h > 1 && $urandom_range(0, 4) == 0)
                resize_mid_frame(int'($urandom_range(1, cur_w * cur_h - 1)),
                                 int'($urandom_range(1, cur_w)),
                                 int'($urandom_range(1, cur_h)));
        end

        idle_on = 1'b1;
        wait_drained();
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
